// ===== rtl/serial_packet_deframer_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the serial packet deframer
// Concurrent checks that are compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SERIAL_PACKET_DEFRAMER_UNIT_DEFINES_SVH
`define SERIAL_PACKET_DEFRAMER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Implication checked every cycle outside reset
`define SPD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequent is checked in the next cycle
`define SPD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SPD_ASSERT_IMP(lbl, ante, cons, msg)
`define SPD_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/spd_pkg.sv =====
// ----------------------------------------------------------------------------
// Serial packet deframer package
// Framing constants, status codes, parser phases and the rotate-add checksum.
// ----------------------------------------------------------------------------
package spd_pkg;

  localparam logic [7:0] HEAD_BYTE     = 8'hCC;
  localparam logic [7:0] TAIL_BYTE     = 8'hB9;
  localparam logic [7:0] MAX_LEN_RESET = 8'd128;
  // checksum rotates right by one: bit 0 moves to this position
  localparam int         SUM_TOP_BIT   = 7;

  // result status codes
  typedef enum logic [3:0] {
    ST_HUNT       = 4'd0,
    ST_FRAMING    = 4'd1,
    ST_DATA       = 4'd2,
    ST_OK         = 4'd3,
    ST_BAD_LEN    = 4'd4,
    ST_ZERO_ID    = 4'd5,
    ST_EARLY_TAIL = 4'd6,
    ST_OVERLONG   = 4'd7,
    ST_BAD_SUM    = 4'd8
  } status_t;

  // parser phases, one-hot
  typedef enum logic [4:0] {
    PH_HUNT    = 5'b00001,
    PH_LEN     = 5'b00010,
    PH_ID      = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_CHECK   = 5'b10000
  } phase_t;

  // held input item between the input stage and the parser
  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
  } stage_t;

  // rotate right by one, then add the byte modulo 256
  function automatic logic [7:0] sum_update(input logic [7:0] sum, input logic [7:0] b);
    logic [7:0] rot;
    rot = {sum[0], sum[SUM_TOP_BIT:1]};
    return rot + b;
  endfunction

endpackage

// ===== rtl/spd_byte_if.sv =====
// ----------------------------------------------------------------------------
// Received byte channel
// valid/ready channel carrying one serial byte per item.
// ----------------------------------------------------------------------------
interface spd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/spd_result_if.sv =====
// ----------------------------------------------------------------------------
// Deframer result channel
// valid/ready channel carrying one parse result per item.
// ----------------------------------------------------------------------------
interface spd_result_if;
  logic       valid;
  logic       ready;
  logic [3:0] status;
  logic [7:0] data_byte;
  logic [7:0] byte_index;
  logic [7:0] message_id;
  logic [7:0] frame_len;
  logic [7:0] running_sum;

  modport source (output valid, output status, output data_byte, output byte_index,
                  output message_id, output frame_len, output running_sum, input ready);
  modport sink (input valid, input status, input data_byte, input byte_index,
                input message_id, input frame_len, input running_sum, output ready);
endinterface

// ===== rtl/spd_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Deframer configuration channel
// valid/ready write channel for the maximum length register.
// ----------------------------------------------------------------------------
interface spd_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] max_payload_len;

  modport source (output valid, output max_payload_len, input ready);
  modport sink (input valid, input max_payload_len, output ready);
endinterface

// ===== rtl/spd_in_stage.sv =====
// ----------------------------------------------------------------------------
// Deframer input stage
// Registers one received byte; refills in the cycle the parser takes it.
// ----------------------------------------------------------------------------
module spd_in_stage
  import spd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  spd_byte_if.sink    bytes,
  input  logic        take,
  output stage_t      held
);

  logic       valid;
  logic [7:0] rx_byte;

  // room when empty or when the held item leaves this cycle
  assign bytes.ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (bytes.valid && bytes.ready) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (bytes.valid && bytes.ready) begin
      rx_byte <= bytes.rx_byte;
    end
  end

  assign held.valid   = valid;
  assign held.rx_byte = rx_byte;

endmodule

// ===== rtl/spd_parser.sv =====
// ----------------------------------------------------------------------------
// Deframer parser
// Frame state machine, checksum and the result register.
// ----------------------------------------------------------------------------
module spd_parser
  import spd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  stage_t       held,
  input  logic [7:0]   max_len,
  output logic         take,
  spd_result_if.source results
);

  phase_t     phase, phase_next;
  logic [7:0] length_reg, length_reg_next;
  logic [7:0] byte_count, byte_count_next;
  logic [7:0] id_reg, id_reg_next;
  logic [7:0] sum_reg, sum_reg_next;

  status_t    status_c;
  logic [7:0] data_c;
  logic [7:0] idx_c;
  logic [7:0] b;

  logic       res_valid;
  status_t    res_status;
  logic [7:0] res_data;
  logic [7:0] res_idx;

  // move the held item into the result register when that register frees up
  assign take = held.valid && (!res_valid || results.ready);
  assign b    = held.rx_byte;

  // next state and result for the held byte
  always_comb begin
    phase_next      = phase;
    length_reg_next = length_reg;
    byte_count_next = byte_count;
    id_reg_next     = id_reg;
    sum_reg_next    = sum_reg;
    status_c        = ST_HUNT;
    data_c          = '0;
    idx_c           = '0;
    unique case (phase)
      PH_LEN: begin
        if (b == '0 || b > max_len) begin
          status_c   = ST_BAD_LEN;
          phase_next = PH_HUNT;
        end else begin
          length_reg_next = b;
          status_c        = ST_FRAMING;
          phase_next      = PH_ID;
        end
      end
      PH_ID: begin
        if (b == '0) begin
          status_c   = ST_ZERO_ID;
          phase_next = PH_HUNT;
        end else begin
          id_reg_next     = b;
          sum_reg_next    = sum_update('0, b);
          data_c          = b;
          byte_count_next = 8'd1;
          status_c        = ST_DATA;
          phase_next      = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (b != TAIL_BYTE && byte_count < length_reg) begin
          data_c          = b;
          idx_c           = byte_count;
          byte_count_next = byte_count + 8'd1;
          sum_reg_next    = sum_update(sum_reg, b);
          status_c        = ST_DATA;
        end else if (b == TAIL_BYTE) begin
          if (byte_count != length_reg) begin
            status_c   = ST_EARLY_TAIL;
            phase_next = PH_HUNT;
          end else begin
            status_c   = ST_FRAMING;
            phase_next = PH_CHECK;
          end
        end else begin
          status_c   = ST_OVERLONG;
          phase_next = PH_HUNT;
        end
      end
      PH_CHECK: begin
        status_c   = (b == sum_reg) ? ST_OK : ST_BAD_SUM;
        phase_next = PH_HUNT;
      end
      default: begin
        // hunt, and any stray code behaves as hunt
        if (b == HEAD_BYTE) begin
          status_c   = ST_FRAMING;
          phase_next = PH_LEN;
        end else begin
          status_c   = ST_HUNT;
          phase_next = PH_HUNT;
        end
      end
    endcase
  end

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT;
      length_reg <= '0;
      byte_count <= '0;
      id_reg     <= '0;
      sum_reg    <= '0;
    end else if (take) begin
      phase      <= phase_next;
      length_reg <= length_reg_next;
      byte_count <= byte_count_next;
      id_reg     <= id_reg_next;
      sum_reg    <= sum_reg_next;
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  // result payload; id, length and sum are read from the state registers
  always_ff @(posedge clk) begin
    if (take) begin
      res_status <= status_c;
      res_data   <= data_c;
      res_idx    <= idx_c;
    end
  end

  assign results.valid       = res_valid;
  assign results.status      = res_status;
  assign results.data_byte   = res_data;
  assign results.byte_index  = res_idx;
  assign results.message_id  = id_reg;
  assign results.frame_len   = length_reg;
  assign results.running_sum = sum_reg;

endmodule

// ===== rtl/serial_packet_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// Serial packet deframer
// Byte-serial parser for frames: head CC, length, ID, payload, tail B9, sum.
// ----------------------------------------------------------------------------
// Usage:
//   bytes   : one received byte per item (valid/ready).
//   results : one result per byte: status, payload byte and its index,
//             message ID, length byte and running checksum (valid/ready).
//   cfg     : write of the maximum length byte; always ready, to be
//             written only while no item is in flight.
// A byte accepted into the input register waits there and enters the result
// register once that register is empty or its result is being taken.
// Throughput is one item per cycle while the receiver takes results, set
// by the frame state machine between the two registers.
// Reset clears the frame state to hunting with zero ID, length and sum,
// empties both registers and sets the maximum length to 128.
// When the receiver stalls, the result register holds, the input register
// still takes one more byte, and bytes.ready then drops until the
// result is taken.
// ----------------------------------------------------------------------------
`include "serial_packet_deframer_unit_defines.svh"

module serial_packet_deframer_unit
  import spd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  spd_byte_if.sink     bytes,
  spd_result_if.source results,
  spd_cfg_if.sink      cfg
);

  logic [7:0] max_len;
  logic       take;
  stage_t     held;

  // configuration register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= MAX_LEN_RESET;
    end else if (cfg.valid && cfg.ready) begin
      max_len <= cfg.max_payload_len;
    end
  end

  // input register
  spd_in_stage u_in_stage (
    .clk   (clk),
    .rst   (rst),
    .bytes (bytes),
    .take  (take),
    .held  (held)
  );

  // parser and result register
  spd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .held    (held),
    .max_len (max_len),
    .take    (take),
    .results (results)
  );

  // a payload byte always lies inside the announced length
  `SPD_ASSERT_IMP(a_data_in_len,
                  results.valid && results.status == ST_DATA,
                  results.byte_index < results.frame_len,
                  "payload byte index beyond frame length")

  // the tail value should not be reported as payload; an ID byte equal to it carries ST_DATA and trips this check
  `SPD_ASSERT_IMP(a_no_tail_data,
                  results.valid && results.status == ST_DATA,
                  results.data_byte != TAIL_BYTE,
                  "tail byte reported as payload")

  // with both registers full and the receiver stalled, no byte is taken
  `SPD_ASSERT_IMP(a_full_stall,
                  held.valid && results.valid && !results.ready,
                  !bytes.ready,
                  "byte accepted while both stages are full")

  // a held byte moves to the result side in the cycle it is taken
  `SPD_ASSERT_NXT(a_take_result,
                  take,
                  results.valid,
                  "taken byte produced no result")

endmodule
